// File: sv/lpm_pkg.sv
// shared types and constants for the longest prefix match table
package lpm_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SLOT_W = 4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef struct packed {
        logic  valid;
        addr_t prefix;
        addr_t mask;
    } lpm_entry_t;

endpackage

// File: sv/lpm_store.sv
// prefix and mask memory with per-slot valid flags and a registered read port
module lpm_store
    import lpm_pkg::*;
#(
    parameter int unsigned ENTRIES = 16,
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  lpm_entry_t       wr_entry,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output lpm_entry_t       rd_entry
);

    addr_t               prefix_mem [ENTRIES];
    addr_t               mask_mem   [ENTRIES];
    logic  [ENTRIES-1:0] valid_reg;
    lpm_entry_t          rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= wr_entry.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prefix_mem[wr_addr] <= wr_entry.prefix;
            mask_mem[wr_addr]   <= wr_entry.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg.valid  <= valid_reg[rd_addr];
            rd_entry_reg.prefix <= prefix_mem[rd_addr];
            rd_entry_reg.mask   <= mask_mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// File: sv/longest_prefix_match_table.sv
// longest prefix match routing table, top level with scan sequencer and compare unit
// a table write is taken on the input transfer and gives no transfer on the result side
// a lookup walks every slot through one compare unit, one slot per cycle
// lookup result is registered from ST_HOLD after the ST_SCAN and ST_LAST states
// ST_HOLD waits while a result is pending, and a new input is taken only in ST_IDLE
// reset clears all valid flags at once, no clearing pass, prefix and mask memory not reset
module longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [3:0]  s_entry_slot,
    input  logic [31:0] s_entry_prefix,
    input  logic [31:0] s_entry_mask,
    input  logic        s_entry_enable,
    input  logic [31:0] s_lookup_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [3:0]  m_match_slot,
    output logic [31:0] m_match_mask
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    addr_t              addr_reg, addr_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_slot_reg, best_slot_next;
    addr_t              best_mask_reg, best_mask_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_hit_reg, m_hit_next;
    slot_t              m_slot_reg, m_slot_next;
    addr_t              m_mask_reg, m_mask_next;

    logic               in_xfer;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    lpm_entry_t         wr_entry;
    logic               rd_en;
    lpm_entry_t         rd_entry;
    logic               entry_match;
    logic               entry_better;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign wr_en    = in_xfer && (s_mode == MODE_WRITE)
                      && (9'(s_entry_slot) < 9'(TABLE_ENTRIES));
    assign wr_addr  = IDX_W'(s_entry_slot);
    assign wr_entry = '{valid: s_entry_enable, prefix: s_entry_prefix, mask: s_entry_mask};
    assign rd_en    = (state_reg == ST_SCAN);
    assign out_free = !m_valid_reg || m_ready;

    lpm_store #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (scan_idx_reg),
        .rd_entry (rd_entry)
    );

    // shared compare unit
    assign entry_match  = cmp_vld_reg && rd_entry.valid
                          && (((rd_entry.prefix ^ addr_reg) & rd_entry.mask) == '0);
    assign entry_better = entry_match && (!found_reg || (rd_entry.mask > best_mask_reg));

    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = 1'b0;
        addr_next      = addr_reg;
        found_next     = found_reg;
        best_slot_next = best_slot_reg;
        best_mask_next = best_mask_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hit_next     = m_hit_reg;
        m_slot_next    = m_slot_reg;
        m_mask_next    = m_mask_reg;

        if (entry_better) begin
            found_next     = 1'b1;
            best_slot_next = cmp_idx_reg;
            best_mask_next = rd_entry.mask;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_mode == MODE_LOOKUP)) begin
                    addr_next      = s_lookup_address;
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    best_slot_next = '0;
                    best_mask_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_LAST;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_LAST: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = found_reg;
                    m_slot_next  = SLOT_W'(best_slot_reg);
                    m_mask_next  = best_mask_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        addr_reg      <= addr_next;
        found_reg     <= found_next;
        best_slot_reg <= best_slot_next;
        best_mask_reg <= best_mask_next;
        m_hit_reg     <= m_hit_next;
        m_slot_reg    <= m_slot_next;
        m_mask_reg    <= m_mask_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_match_slot = m_slot_reg;
    assign m_match_mask = m_mask_reg;

`ifndef SYNTHESIS
    a_idle_no_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmp_vld_reg)
        else $error("compare pending while idle");

    a_lookup_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_mode == MODE_LOOKUP)) |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("lookup did not start scan at slot zero");

    a_last_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LAST) |-> cmp_vld_reg ##1 (state_reg == ST_HOLD))
        else $error("final slot compare out of sequence");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_match_slot == '0) && (m_match_mask == '0))
        else $error("miss result carries nonzero slot or mask");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_match_mask) && $stable(m_match_slot))
        else $error("pending result overwritten");
`endif

endmodule
